### hdl/timing_bit_slicer_deframer_macros.svh
// Assertion macros shared by the timing bit slicer deframer modules.
// Depends on nothing; each user must have clk and arst_n in scope.
`ifndef TIMING_BIT_SLICER_DEFRAMER_MACROS_SVH
`define TIMING_BIT_SLICER_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tbsd_pkg.sv
// Package for the timing bit slicer deframer: sizes, register indexes,
// payload structs and the phase encoding. Depends on nothing.
`timescale 1ns / 1ps

package tbsd_pkg;

	localparam int MAX_MESSAGE_BYTES = 128;
	localparam int COUNT_WIDTH       = 16;

	localparam int TIME_W      = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int DEC_W       = COUNT_WIDTH + 3;
	localparam int MSG_BIT_W   = $clog2(MAX_MESSAGE_BYTES * 8 + 1);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [MSG_BIT_W-1:0] MSG_BITS_MAX = MSG_BIT_W'(MAX_MESSAGE_BYTES * 8);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_HIT_BOUNDARY  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTLIER_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_PATTERN  = 2'd2;

	localparam logic [TIME_W-1:0] HIT_BOUNDARY_RST  = 16'd100;
	localparam logic [TIME_W-1:0] OUTLIER_LIMIT_RST = 16'd1000;
	localparam logic [7:0]        SYNC_PATTERN_RST  = 8'b1001_1011;

	// Request kinds.
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	// Phase codes as seen on the result port.
	localparam logic [1:0] PHASE_CODE_SEEK = 2'd0;
	localparam logic [1:0] PHASE_CODE_SYNC = 2'd1;
	localparam logic [1:0] PHASE_CODE_MSG  = 2'd2;

	typedef enum logic [2:0] {
		PH_SEEK = 3'b001,
		PH_SYNC = 3'b010,
		PH_MSG  = 3'b100
	} phase_t;

	typedef struct packed {
		logic              req_type;
		logic [TIME_W-1:0] access_time;
	} req_t;

	typedef struct packed {
		logic       bit_value;
		logic [1:0] phase;
		logic       realign;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       last;
	} res_t;

	// Per-period decision handed from the slicer to the framer.
	typedef struct packed {
		logic bit_value;
		logic realign;
	} decision_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_SEEK: code = PHASE_CODE_SEEK;
			PH_SYNC: code = PHASE_CODE_SYNC;
			PH_MSG:  code = PHASE_CODE_MSG;
			default: code = PHASE_CODE_SEEK;
		endcase
		return code;
	endfunction

endpackage

### hdl/tbsd_slicer.sv
// Sample counters and per-period bit decision of the deframer.
// Depends on tbsd_pkg.
`timescale 1ns / 1ps

module tbsd_slicer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_en,
	input  logic                         tick_en,
	input  logic [tbsd_pkg::TIME_W-1:0]  access_time,
	input  logic [tbsd_pkg::TIME_W-1:0]  hit_boundary,
	input  logic [tbsd_pkg::TIME_W-1:0]  outlier_limit,
	input  logic                         seek,
	output tbsd_pkg::decision_t          dec
);
	import tbsd_pkg::*;

	logic [COUNT_WIDTH-1:0] sample_count_q;
	logic [COUNT_WIDTH-1:0] hit_count_q;
	logic [COUNT_WIDTH-1:0] hits_clip;
	logic [DEC_W-1:0]       n_x;
	logic [DEC_W-1:0]       h_x;
	logic [DEC_W-1:0]       m_x;
	logic                   counted;
	logic                   is_hit;

	assign counted = (access_time <= outlier_limit);
	assign is_hit  = counted && (access_time <= hit_boundary);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			hit_count_q    <= '0;
		end else if (tick_en) begin
			sample_count_q <= '0;
			hit_count_q    <= '0;
		end else if (sample_en) begin
			if (counted && sample_count_q != CNT_MAX)
				sample_count_q <= sample_count_q + COUNT_WIDTH'(1);
			if (is_hit && hit_count_q != CNT_MAX)
				hit_count_q <= hit_count_q + COUNT_WIDTH'(1);
		end
	end

	// The ratio tests are exact cross products by small constants.
	assign hits_clip = (hit_count_q > sample_count_q) ? sample_count_q : hit_count_q;
	assign n_x = DEC_W'(sample_count_q);
	assign h_x = DEC_W'(hits_clip);
	assign m_x = n_x - h_x;

	always_comb begin
		if (seek) begin
			dec.bit_value = ((h_x << 2) + h_x) < (n_x << 2);
			dec.realign   = ((m_x << 2) + m_x) > n_x;
		end else begin
			dec.bit_value = (h_x << 1) < n_x;
			dec.realign   = 1'b0;
		end
	end

endmodule

### hdl/tbsd_framer.sv
// Sync matcher and message byte packer of the deframer.
// Depends on tbsd_pkg.
`timescale 1ns / 1ps

module tbsd_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_en,
	input  tbsd_pkg::decision_t dec,
	input  logic [7:0]          sync_pattern,
	output logic                seek,
	output tbsd_pkg::res_t      res
);
	import tbsd_pkg::*;

	phase_t                 phase_q, phase_d;
	logic [2:0]             pos_q, pos_d;
	logic [MSG_BIT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic [7:0]             shift_q, shift_d, shifted;
	logic                   byte_valid;
	logic [7:0]             byte_value;
	logic                   last;

	assign cnt_inc = cnt_q + MSG_BIT_W'(1);
	assign shifted = {shift_q[6:0], dec.bit_value};

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		cnt_d      = cnt_q;
		shift_d    = shift_q;
		byte_valid = 1'b0;
		byte_value = 8'd0;
		last       = 1'b0;
		case (phase_q)
			PH_SEEK: begin
				if (dec.bit_value == sync_pattern[7]) begin
					phase_d = PH_SYNC;
					pos_d   = 3'd1;
				end
			end
			PH_SYNC: begin
				if (dec.bit_value == sync_pattern[3'd7 - pos_q]) begin
					if (pos_q == 3'd7) begin
						phase_d = PH_MSG;
						pos_d   = 3'd0;
						cnt_d   = '0;
						shift_d = 8'd0;
					end else begin
						pos_d = pos_q + 3'd1;
					end
				end else begin
					phase_d = PH_SEEK;
					pos_d   = 3'd0;
					cnt_d   = '0;
					shift_d = 8'd0;
				end
			end
			PH_MSG: begin
				shift_d = shifted;
				cnt_d   = cnt_inc;
				if (cnt_inc[2:0] == 3'd0) begin
					byte_valid = 1'b1;
					byte_value = shifted;
					if (shifted == 8'd0 || cnt_inc >= MSG_BITS_MAX) begin
						last    = 1'b1;
						phase_d = PH_SEEK;
						pos_d   = 3'd0;
						cnt_d   = '0;
						shift_d = 8'd0;
					end else begin
						shift_d = 8'd0;
					end
				end
			end
			default: begin
				phase_d = PH_SEEK;
				pos_d   = 3'd0;
				cnt_d   = '0;
				shift_d = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			pos_q   <= 3'd0;
			cnt_q   <= '0;
			shift_q <= 8'd0;
		end else if (tick_en) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
		end
	end

	assign seek = (phase_q == PH_SEEK);

	always_comb begin
		res.bit_value  = dec.bit_value;
		res.phase      = phase_code(phase_d);
		res.realign    = dec.realign;
		res.byte_valid = byte_valid;
		res.byte_value = byte_value;
		res.last       = last;
	end

endmodule

### hdl/timing_bit_slicer_deframer.sv
// Top level of the timing bit slicer deframer: request register, result
// register and configuration registers. Depends on tbsd_pkg, tbsd_slicer,
// tbsd_framer and timing_bit_slicer_deframer_macros.svh.
`timescale 1ns / 1ps

// The block takes one request per clock cycle, sustained while no tick waits
// on a full result register. A sample request updates the hit and sample
// counters and gives no result. A tick request slices the period into one bit,
// runs the sync matcher and byte packer, and places one result in the output
// register. Every request first lands in a request register; from there the
// counter update, the ratio decision and the framer step run as one pass of
// short logic, and a tick's result is loaded into the result register once it
// is free. The figure of one request per cycle is set by that single pass
// through the counters and framer state.
// While a result waits in the output register, the request register still
// accepts a request; a tick in the request register then waits for the result
// to be taken, while samples pass on freely. Configuration writes take effect
// at once and are meant for times when no request is in flight; writes to an
// unknown index are ignored.
module timing_bit_slicer_deframer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tbsd_pkg::req_t                     in_req,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tbsd_pkg::res_t                     out_res,
	input  logic                               cfg_we,
	input  logic [tbsd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [tbsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tbsd_pkg::*;

	`include "timing_bit_slicer_deframer_macros.svh"

	logic               in_valid_s1;
	req_t               in_req_s1;
	logic               out_valid_q;
	res_t               out_res_q;
	logic [TIME_W-1:0]  hit_boundary_q;
	logic [TIME_W-1:0]  outlier_limit_q;
	logic [7:0]         sync_pattern_q;

	logic               s1_is_tick;
	logic               out_free;
	logic               s1_fire;
	logic               sample_en;
	logic               tick_en;
	logic               seek;
	decision_t          dec;
	res_t               res;

	// Configuration registers; the high byte of a sync pattern write is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_boundary_q  <= HIT_BOUNDARY_RST;
			outlier_limit_q <= OUTLIER_LIMIT_RST;
			sync_pattern_q  <= SYNC_PATTERN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIT_BOUNDARY:  hit_boundary_q  <= cfg_data[TIME_W-1:0];
				REG_OUTLIER_LIMIT: outlier_limit_q <= cfg_data[TIME_W-1:0];
				REG_SYNC_PATTERN:  sync_pattern_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// A sample never needs the result register; a tick needs it free or
	// being emptied in this cycle.
	assign s1_is_tick = (in_req_s1.req_type == REQ_TICK);
	assign out_free   = !out_valid_q || out_ready;
	assign s1_fire    = in_valid_s1 && (!s1_is_tick || out_free);
	assign in_ready   = !in_valid_s1 || s1_fire;
	assign sample_en  = s1_fire && !s1_is_tick;
	assign tick_en    = s1_fire && s1_is_tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_req_s1 <= in_req;
	end

	tbsd_slicer u_slicer (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_en     (sample_en),
		.tick_en       (tick_en),
		.access_time   (in_req_s1.access_time),
		.hit_boundary  (hit_boundary_q),
		.outlier_limit (outlier_limit_q),
		.seek          (seek),
		.dec           (dec)
	);

	tbsd_framer u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_en      (tick_en),
		.dec          (dec),
		.sync_pattern (sync_pattern_q),
		.seek         (seek),
		.res          (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_en)
			out_res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	// A message end always carries its byte and leaves the block in seek.
	`TBSD_ASSERT_NOW(a_last_ends_message, out_valid_q && out_res_q.last,
		out_res_q.byte_valid && out_res_q.phase == PHASE_CODE_SEEK,
		"last without a byte or without a return to seek")
	// Byte fields stay zero when no byte was completed.
	`TBSD_ASSERT_NOW(a_no_byte_zero, out_valid_q && !out_res_q.byte_valid,
		out_res_q.byte_value == 8'd0 && !out_res_q.last,
		"byte fields set without a completed byte")
	// Realign comes only from a seek-mode decision, which cannot end in message mode.
	`TBSD_ASSERT_NOW(a_realign_from_seek, out_valid_q && out_res_q.realign,
		out_res_q.phase != PHASE_CODE_MSG,
		"realign raised outside seek")
	// A tick held in the request register stays there until the result slot frees.
	`TBSD_ASSERT_NEXT(a_tick_waits, in_valid_s1 && !s1_fire,
		in_valid_s1 && $stable(in_req_s1),
		"stalled request lost from the request register")

endmodule
